### design/clu_pkg.sv
// shared types, codes and constants of the line unfolder
package clu_pkg;

  // reset value of the line length limit
  localparam logic [7:0] MaxLenReset = 8'd75;
  // default depth of the queue between front and back
  localparam int unsigned QueueDepthDefault = 4;
  // results one input byte can cause at most
  localparam int unsigned MaxResults = 3;

  // characters the front looks for
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChSemi = 8'h3B;

  // kind of one result
  typedef enum logic [1:0] {
    KindByte = 2'd0,
    KindEol  = 2'd1,
    KindErr  = 2'd2
  } kind_e;

  // format error codes
  typedef enum logic [2:0] {
    ErrNone    = 3'd0,
    ErrBareCr  = 3'd1,
    ErrCrEnd   = 3'd2,
    ErrLoneLf  = 3'd3,
    ErrTooLong = 3'd4
  } err_e;

  // parser phase, one-hot
  typedef enum logic [3:0] {
    PhText  = 4'b0001,
    PhCr    = 4'b0010,
    PhCrlf  = 4'b0100,
    PhError = 4'b1000
  } phase_e;

  // one result item
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    err_e        code;
  } result_t;

  // all results of one input byte, in order, res[0] first
  typedef struct packed {
    logic [1:0]                  cnt;
    result_t [MaxResults-1:0]    res;
  } entry_t;

endpackage

### design/crlf_line_unfolder_top.sv
// top level of the content line unfolder
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata[7:0] data_byte, tlast stream_end
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata[7:0] out_byte, [10:8] error_code,
//                                               tuser[1:0] kind, tlast run_last
//  cfg       in   cfg_valid_i/cfg_ready_o       cfg_data_i max_line_length
//
// one input byte per cycle is taken while the group queue has room
// a byte causing n results offers them in order, one result per output transfer
// first result is offered from the output group register after its group has passed the queue
// the output group register lets input flow while a result waits
// reset clears line state, queue and output valid; limit returns to 75
module crlf_line_unfolder_top #(
  parameter int unsigned QueueDepth = clu_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  logic             push;
  logic             pop;
  logic             empty;
  logic             full;
  clu_pkg::entry_t  push_entry;
  clu_pkg::entry_t  head;
  clu_pkg::result_t res;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !full;

  // byte classifier and line state
  clu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_end_i   (s_axis_tlast),
    .in_ready_i (s_axis_tready),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // result group queue
  clu_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .full_o      (full)
  );

  // result serializer
  clu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_res_o  (res),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, res.code, res.data};
  assign m_axis_tuser = res.kind;

endmodule

### design/clu_front.sv
// front part: accepts bytes, tracks line state and builds the result group
module clu_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  input  logic [7:0]      cfg_data_i,
  input  logic            in_valid_i,
  input  logic [7:0]      in_byte_i,
  input  logic            in_end_i,
  input  logic            in_ready_i,
  output logic            push_o,
  output clu_pkg::entry_t entry_o
);

  clu_pkg::phase_e ph_q, ph_d;
  logic [7:0] len_q, len_d;
  logic       st_q, st_d;
  logic       cm_q, cm_d;
  logic [7:0] max_q;
  logic       accept;
  logic       run_text;
  logic       is_fold;
  logic       t_cm;
  clu_pkg::entry_t e;

  // append one result to a group
  function automatic clu_pkg::entry_t add_res(clu_pkg::entry_t g, clu_pkg::kind_e k,
                                              logic [7:0] d, clu_pkg::err_e c);
    clu_pkg::entry_t r;
    r = g;
    r.res[r.cnt].kind = k;
    r.res[r.cnt].data = d;
    r.res[r.cnt].code = c;
    r.cnt = r.cnt + 2'd1;
    return r;
  endfunction

  assign accept  = in_valid_i && in_ready_i;
  assign is_fold = (in_byte_i == clu_pkg::ChSpace) || (in_byte_i == clu_pkg::ChTab);

  // classify the byte and work out the next line state
  always_comb begin
    e        = '0;
    ph_d     = ph_q;
    len_d    = len_q;
    st_d     = st_q;
    cm_d     = cm_q;
    run_text = 1'b0;
    t_cm     = 1'b0;
    case (ph_q)
      clu_pkg::PhText: begin
        run_text = 1'b1;
      end
      clu_pkg::PhCr: begin
        if (in_byte_i != clu_pkg::ChLf) begin
          e    = add_res(e, clu_pkg::KindErr, 8'd0, clu_pkg::ErrBareCr);
          ph_d = clu_pkg::PhError;
        end else if (len_q > max_q) begin
          e    = add_res(e, clu_pkg::KindErr, 8'd0, clu_pkg::ErrTooLong);
          ph_d = clu_pkg::PhError;
        end else if (in_end_i) begin
          ph_d = clu_pkg::PhText;
          if (!cm_q) e = add_res(e, clu_pkg::KindEol, 8'd0, clu_pkg::ErrNone);
        end else begin
          ph_d = clu_pkg::PhCrlf;
        end
      end
      clu_pkg::PhCrlf: begin
        ph_d = clu_pkg::PhText;
        if (is_fold) begin
          len_d = 8'd0;
          if (in_end_i && !cm_q) e = add_res(e, clu_pkg::KindEol, 8'd0, clu_pkg::ErrNone);
        end else begin
          // close the previous logical line, then treat the byte as text
          if (!cm_q) e = add_res(e, clu_pkg::KindEol, 8'd0, clu_pkg::ErrNone);
          len_d    = 8'd0;
          st_d     = 1'b0;
          cm_d     = 1'b0;
          run_text = 1'b1;
        end
      end
      clu_pkg::PhError: begin
        ph_d = clu_pkg::PhError;
      end
      default: begin
        ph_d = clu_pkg::PhError;
      end
    endcase

    // plain text byte handling
    if (run_text) begin
      if (in_byte_i == clu_pkg::ChCr) begin
        if (in_end_i) begin
          e    = add_res(e, clu_pkg::KindErr, 8'd0, clu_pkg::ErrCrEnd);
          ph_d = clu_pkg::PhError;
        end else begin
          ph_d = clu_pkg::PhCr;
        end
      end else if (in_byte_i == clu_pkg::ChLf) begin
        e    = add_res(e, clu_pkg::KindErr, 8'd0, clu_pkg::ErrLoneLf);
        ph_d = clu_pkg::PhError;
      end else begin
        t_cm = st_d ? cm_d : (in_byte_i == clu_pkg::ChSemi);
        st_d = 1'b1;
        cm_d = t_cm;
        if (!t_cm) e = add_res(e, clu_pkg::KindByte, in_byte_i, clu_pkg::ErrNone);
        if (len_d != 8'hFF) len_d = len_d + 8'd1;
        if (in_end_i && !t_cm) e = add_res(e, clu_pkg::KindEol, 8'd0, clu_pkg::ErrNone);
      end
    end

    // stream end restarts the stream state
    if (in_end_i) begin
      ph_d  = clu_pkg::PhText;
      len_d = 8'd0;
      st_d  = 1'b0;
      cm_d  = 1'b0;
    end
  end

  // line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= clu_pkg::PhText;
      len_q <= 8'd0;
      st_q  <= 1'b0;
      cm_q  <= 1'b0;
    end else if (accept) begin
      ph_q  <= ph_d;
      len_q <= len_d;
      st_q  <= st_d;
      cm_q  <= cm_d;
    end
  end

  // line length limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= clu_pkg::MaxLenReset;
    end else if (cfg_valid_i) begin
      max_q <= cfg_data_i;
    end
  end

  assign push_o  = accept && (e.cnt != 2'd0);
  assign entry_o = e;

endmodule

### design/clu_queue.sv
// short queue of result groups between front and back
module clu_queue #(
  parameter int unsigned Depth = clu_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  clu_pkg::entry_t push_entry_i,
  input  logic            pop_i,
  output clu_pkg::entry_t head_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  clu_pkg::entry_t    mem_q [Depth];
  logic [PtrW-1:0]    wr_q, rd_q;
  logic [CntW-1:0]    cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntFull);
  assign head_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_entry_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
      if (pop_i)  rd_q <= (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

### design/clu_back.sv
// back part: hands out the results of each group one per cycle while the receiver is ready
module clu_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  clu_pkg::entry_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output clu_pkg::result_t out_res_o,
  output logic            out_last_o
);

  logic            hold_q;
  clu_pkg::entry_t grp_q;
  logic [1:0]      pos_q;
  logic            last;
  logic            take_last;
  logic            load;

  assign last      = (pos_q == (grp_q.cnt - 2'd1));
  assign take_last = hold_q && out_ready_i && last;
  assign load      = !empty_i && (!hold_q || take_last);
  assign pop_o     = load;

  // output group register and position within it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      pos_q  <= 2'd0;
    end else if (load) begin
      hold_q <= 1'b1;
      pos_q  <= 2'd0;
    end else if (take_last) begin
      hold_q <= 1'b0;
      pos_q  <= 2'd0;
    end else if (hold_q && out_ready_i) begin
      pos_q  <= pos_q + 2'd1;
    end
  end

  // group payload
  always_ff @(posedge clk_i) begin
    if (load) grp_q <= head_i;
  end

  assign out_valid_o = hold_q;
  assign out_res_o   = grp_q.res[pos_q];
  assign out_last_o  = last;

endmodule

### design/clu_checker.sv
// port checker for the line unfolder and its bind
module clu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // an error ends the results of its byte and carries a code
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == clu_pkg::KindErr) |->
      m_axis_tlast && (m_axis_tdata[10:8] != clu_pkg::ErrNone))
    else $error("error result not last or without code");

  // only content bytes carry a byte value
  a_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != clu_pkg::KindByte) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("byte value on non-content result");

  // only errors carry an error code
  a_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != clu_pkg::KindErr) |-> (m_axis_tdata[15:8] == 8'd0))
    else $error("error code on non-error result");

endmodule

bind crlf_line_unfolder_top clu_checker u_clu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

### bench/tb_top.sv
// self-checking bench of the content line unfolder: streams, folds, comments and format errors
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any request before the run is given up
  localparam int unsigned StallLimit = 2000;
  // long receiver hold that fills the group queue
  localparam int unsigned HoldCycles = 60;
  // cycles to let in-flight bytes settle once no result is due
  localparam int unsigned SettleCycles = 12;

  // one expected result of the unfolder
  typedef struct packed {
    clu_pkg::kind_e kind;
    logic [7:0]     data;
    clu_pkg::err_e  code;
    logic           last;
  } unfold_res_t;

  // unfolding predictor and queue of results still due
  class unfold_scoreboard;
    logic [7:0]      max_len;
    clu_pkg::phase_e phase;
    logic [7:0]      line_len;
    logic            line_started;
    logic            comment_line;
    unfold_res_t     due_results[$];
    int              errors;

    function new();
      max_len = clu_pkg::MaxLenReset;
      errors = 0;
      phase = clu_pkg::PhText;
      clear_line();
    endfunction

    function void clear_line();
      line_len = 8'd0;
      line_started = 1'b0;
      comment_line = 1'b0;
    endfunction

    function void emit(clu_pkg::kind_e k, logic [7:0] d, clu_pkg::err_e c);
      unfold_res_t r;
      r.kind = k;
      r.data = d;
      r.code = c;
      r.last = 1'b0;
      due_results.push_back(r);
    endfunction

    // end-of-line mark unless the line is a comment
    function void close_line();
      if (!comment_line) emit(clu_pkg::KindEol, 8'h00, clu_pkg::ErrNone);
      clear_line();
    endfunction

    function void fail(clu_pkg::err_e c);
      emit(clu_pkg::KindErr, 8'h00, c);
      phase = clu_pkg::PhError;
    endfunction

    // byte seen while no CR is pending
    function void text_byte(logic [7:0] b, logic last);
      if (b == clu_pkg::ChCr) begin
        if (last) fail(clu_pkg::ErrCrEnd);
        else phase = clu_pkg::PhCr;
        return;
      end
      if (b == clu_pkg::ChLf) begin
        fail(clu_pkg::ErrLoneLf);
        return;
      end
      if (!line_started) begin
        line_started = 1'b1;
        comment_line = (b == clu_pkg::ChSemi);
      end
      if (!comment_line) emit(clu_pkg::KindByte, b, clu_pkg::ErrNone);
      if (line_len != 8'hFF) line_len++;
      if (last) close_line();
    endfunction

    function void set_limit(logic [7:0] v);
      max_len = v;
    endfunction

    // predict the results of one accepted byte
    function void unfold_byte(logic [7:0] b, logic last);
      int          before_cnt;
      unfold_res_t tail;
      before_cnt = due_results.size();
      case (phase)
        clu_pkg::PhText: text_byte(b, last);
        clu_pkg::PhCr: begin
          if (b != clu_pkg::ChLf) fail(clu_pkg::ErrBareCr);
          else if (line_len > max_len) fail(clu_pkg::ErrTooLong);
          else if (last) begin
            phase = clu_pkg::PhText;
            close_line();
          end else phase = clu_pkg::PhCrlf;
        end
        clu_pkg::PhCrlf: begin
          phase = clu_pkg::PhText;
          if (b == clu_pkg::ChSpace || b == clu_pkg::ChTab) begin
            line_len = 8'd0;
            if (last) close_line();
          end else begin
            close_line();
            text_byte(b, last);
          end
        end
        default: ;
      endcase
      if (last) begin
        phase = clu_pkg::PhText;
        clear_line();
      end
      if (due_results.size() > before_cnt) begin
        tail = due_results.pop_back();
        tail.last = 1'b1;
        due_results.push_back(tail);
      end
    endfunction

    function void mismatch(string what, int want, int got);
      errors++;
      $display("%0t mismatch in %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    // compare one accepted result with the oldest one due
    function void check_result(clu_pkg::kind_e k, logic [7:0] d, clu_pkg::err_e c,
                               logic last);
      unfold_res_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t result with none due: expected nothing, got kind %0d byte %02h code %0d last %0b",
                 $time, k, d, c, last);
        return;
      end
      want = due_results.pop_front();
      if (want.kind != k) mismatch("kind", want.kind, k);
      if (want.data != d) mismatch("out_byte", want.data, d);
      if (want.code != c) mismatch("error_code", want.code, c);
      if (want.last != last) mismatch("run_last", want.last, last);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] data_byte
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;            // [7:0] out_byte, [10:8] error_code
  logic [1:0]  m_axis_tuser;            // [1:0] kind
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = 8'h00;

  logic        hold_rx = 1'b0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          sent_items = 0;
  int          idle_cycles = 0;
  unfold_scoreboard sb;

  crlf_line_unfolder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // result side: check accepted results, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(clu_pkg::kind_e'(m_axis_tuser), m_axis_tdata[7:0],
                      clu_pkg::err_e'(m_axis_tdata[10:8]), m_axis_tlast);
    end
    m_axis_tready <= !hold_rx && ($urandom_range(0, 99) >= recv_idle);
  end

  // watchdog on cycles without any request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // offer one byte and wait for its request
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.unfold_byte(b, last);
    sent_items++;
  endtask

  // write the line length limit
  task automatic write_limit(input logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_limit(v);
  endtask

  // wait until no result is due and the pipeline has emptied
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [7:0] content_byte();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == clu_pkg::ChCr || v == clu_pkg::ChLf);
    return v;
  endfunction

  // one stream of folded lines with random content, ending and noise
  task automatic send_stream(input int nlines, input int min_seg, input int max_seg);
    logic [7:0] q[$];
    int         segs;
    int         seglen;
    int         ending;
    bit         noisy;
    for (int l = 0; l < nlines; l++) begin
      segs = (max_seg > 20) ? 1 : $urandom_range(1, 3);
      for (int s = 0; s < segs; s++) begin
        // fold: CRLF then space or tab
        if (s > 0) begin
          q.push_back(clu_pkg::ChCr);
          q.push_back(clu_pkg::ChLf);
          q.push_back($urandom_range(0, 1) ? clu_pkg::ChSpace : clu_pkg::ChTab);
        end
        seglen = $urandom_range(min_seg, max_seg);
        for (int k = 0; k < seglen; k++) q.push_back(content_byte());
        if (s == 0 && seglen > 0 && $urandom_range(0, 4) == 0) begin
          q[q.size() - seglen] = clu_pkg::ChSemi;
        end
      end
      q.push_back(clu_pkg::ChCr);
      q.push_back(clu_pkg::ChLf);
    end
    // stream ending: after LF, mid-line, on a fold byte, or on a CR
    ending = $urandom_range(0, 3);
    case (ending)
      1: begin
        void'(q.pop_back());
        void'(q.pop_back());
      end
      2: q.push_back(clu_pkg::ChSpace);
      3: q.push_back(clu_pkg::ChCr);
      default: ;
    endcase
    if (q.size() == 0) q.push_back(content_byte());
    // noise on some streams, any byte value
    noisy = ($urandom_range(0, 2) == 0);
    if (noisy) begin
      foreach (q[i]) if ($urandom_range(0, 19) == 0) q[i] = 8'($urandom_range(0, 255));
    end
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  initial begin
    logic [8:0] directed_q[$];
    int         phase_end;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // slow receiver: directed streams under a limit of two
    send_idle = 21;
    recv_idle = 88;
    write_limit(8'd2);
    directed_q = '{
      // content extremes, tab fold, comment line, end on a fold space
      {1'b0, 8'hFF}, {1'b0, clu_pkg::ChCr}, {1'b0, clu_pkg::ChLf}, {1'b0, clu_pkg::ChTab},
      {1'b0, 8'h00}, {1'b0, clu_pkg::ChCr}, {1'b0, clu_pkg::ChLf}, {1'b0, clu_pkg::ChSemi},
      {1'b0, clu_pkg::ChCr}, {1'b0, clu_pkg::ChLf}, {1'b1, clu_pkg::ChSpace},
      // line too long, error on the final LF
      {1'b0, 8'h61}, {1'b0, 8'h62}, {1'b0, 8'h63}, {1'b0, clu_pkg::ChCr},
      {1'b1, clu_pkg::ChLf},
      // lone LF, then a dropped byte
      {1'b0, clu_pkg::ChLf}, {1'b1, 8'h41},
      // bare CR
      {1'b0, clu_pkg::ChCr}, {1'b1, 8'h42},
      // comment closed by stream end
      {1'b0, clu_pkg::ChSemi}, {1'b1, 8'h43},
      // CR as final byte
      {1'b0, 8'h44}, {1'b1, clu_pkg::ChCr},
      // empty line closed by the LF at end
      {1'b0, clu_pkg::ChCr}, {1'b1, clu_pkg::ChLf}
    };
    foreach (directed_q[i]) send_byte(directed_q[i][7:0], directed_q[i][8]);
    wait_quiet();

    // tightest limit, slow receiver
    write_limit(8'd1);
    while (sent_items < 70) send_stream($urandom_range(1, 5), 0, 3);
    wait_quiet();

    // widest limit with one over-long line, slow sender
    send_idle = 88;
    recv_idle = 21;
    write_limit(8'd254);
    send_stream(1, 256, 256);
    while (sent_items < 360) send_stream($urandom_range(1, 5), 0, 14);
    wait_quiet();

    // random limit, no idling, one long receiver hold
    send_idle = 0;
    recv_idle = 0;
    write_limit(8'($urandom_range(2, 20)));
    fork
      begin
        repeat (15) @(posedge clk_i);
        hold_rx <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_rx <= 1'b0;
      end
    join_none
    phase_end = sent_items + 40;
    while (sent_items < phase_end) send_stream($urandom_range(1, 5), 0, sb.max_len + 2);
    wait_quiet();

    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
